// File: hdl/wsr_pkg.sv
package wsr_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int COEF_BITS     = 24;
  localparam int PHASE_BITS    = 16;
  localparam int GAIN_BITS     = 16;
  localparam int GAIN_FRAC     = 14;
  localparam int STEP_BITS     = 20;
  localparam int PHASE_W       = 24;
  localparam int MAX_OUT       = 8;
  localparam int MIN_STEP      = 8192;
  localparam int IDX_W         = 21;
  localparam int W_BITS        = PHASE_BITS + 1;
  localparam int COEF_FULL     = COEF_BITS + 2;
  localparam int PROD_BITS     = SAMPLE_BITS + COEF_FULL;
  localparam int ACC_BITS      = PROD_BITS + 6;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 20;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STEP, REG_ZC, REG_PLOG, REG_CHAN, REG_GAIN, REG_MUTE
  } cfg_reg_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  // one tap issued to the mac pipeline
  typedef struct packed {
    logic              vld;
    logic [W_BITS-1:0] w;
    logic              inr;
  } tap_t;

endpackage

// File: hdl/wsr_coef_mem.sv
module wsr_coef_mem import wsr_pkg::*; #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  coef_t                    wval,
  input  coef_t                    wdel,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output coef_t                    rval,
  output coef_t                    rdel
);

  logic [2*COEF_BITS-1:0] mem [DEPTH];
  logic [2*COEF_BITS-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wdel, wval};
    end
    rd_r <= mem[raddr];
  end

  assign rval = coef_t'(rd_r[COEF_BITS-1:0]);
  assign rdel = coef_t'(rd_r[2*COEF_BITS-1:COEF_BITS]);

endmodule

// File: hdl/wsr_hist_mem.sv
module wsr_hist_mem import wsr_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  sample_t                  wl,
  input  sample_t                  wr,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output sample_t                  rl,
  output sample_t                  rr
);

  logic [2*SAMPLE_BITS-1:0] mem [DEPTH];
  logic [2*SAMPLE_BITS-1:0] rd_r;
  logic [DEPTH-1:0]         vld_r;
  logic                     ok_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wr, wl};
    end
    rd_r <= mem[raddr];
  end

  // slots never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ok_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      ok_r <= vld_r[raddr];
    end
  end

  assign rl = ok_r ? sample_t'(rd_r[SAMPLE_BITS-1:0]) : '0;
  assign rr = ok_r ? sample_t'(rd_r[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0;

endmodule

// File: hdl/wsr_mac.sv
module wsr_mac import wsr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tap_t                 tap_i,
  input  coef_t                tab_i,
  input  coef_t                del_i,
  input  sample_t              hl_i,
  input  sample_t              hr_i,
  input  logic                 acc_clr,
  input  logic                 fin_go,
  input  logic [GAIN_BITS-1:0] gain,
  input  logic                 mute,
  input  logic                 mono,
  output logic                 busy,
  output logic                 res_vld,
  output sample_t              res_l,
  output sample_t              res_r
);

  localparam int WD_BITS  = W_BITS + COEF_BITS + 1;
  localparam int SH_BITS  = ACC_BITS - (COEF_BITS - 2);
  localparam int FIN_BITS = SH_BITS + GAIN_BITS + 1;
  localparam logic signed [FIN_BITS-1:0] SMAX = FIN_BITS'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [FIN_BITS-1:0] SMIN = FIN_BITS'(-(2**(SAMPLE_BITS-1)));

  tap_t                        s1_r;
  logic                        s2_v_r, s2_inr_r, s3_v_r, s4_v_r;
  logic signed [WD_BITS-1:0]   wd_r;
  coef_t                       tab2_r;
  sample_t                     hl2_r, hr2_r, hl3_r, hr3_r;
  logic signed [COEF_FULL-1:0] c3_r;
  logic signed [PROD_BITS-1:0] pl4_r, pr4_r;
  logic signed [ACC_BITS-1:0]  accl_r, accr_r;
  logic                        f1_v_r, res_vld_r;
  logic signed [FIN_BITS-1:0]  gl_r, gr_r;
  sample_t                     res_l_r, res_r_r;

  logic signed [WD_BITS-1:0]   wd_nxt;
  logic signed [COEF_FULL-1:0] c_nxt;
  logic signed [GAIN_BITS:0]   gain_s;

  function automatic sample_t sat(input logic signed [FIN_BITS-1:0] p);
    logic signed [FIN_BITS-1:0] s;
    s = p >>> GAIN_FRAC;
    if (s > SMAX) begin
      s = SMAX;
    end else if (s < SMIN) begin
      s = SMIN;
    end
    return sample_t'(s[SAMPLE_BITS-1:0]);
  endfunction

  assign wd_nxt = $signed({1'b0, s1_r.w}) * del_i;
  // interpolated coefficient, zero past the end of the table
  assign c_nxt  = s2_inr_r ? COEF_FULL'(tab2_r) + COEF_FULL'(wd_r >>> PHASE_BITS) : '0;
  assign gain_s = $signed({1'b0, gain});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r      <= '0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
      f1_v_r    <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      s1_r      <= tap_i;
      s2_v_r    <= s1_r.vld;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      f1_v_r    <= fin_go;
      res_vld_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    wd_r     <= wd_nxt;
    s2_inr_r <= s1_r.inr;
    tab2_r   <= tab_i;
    hl2_r    <= hl_i;
    hr2_r    <= hr_i;
    c3_r     <= c_nxt;
    hl3_r    <= hl2_r;
    hr3_r    <= hr2_r;
    pl4_r    <= hl3_r * c3_r;
    pr4_r    <= hr3_r * c3_r;
    if (acc_clr) begin
      accl_r <= '0;
      accr_r <= '0;
    end else if (s4_v_r) begin
      accl_r <= accl_r + ACC_BITS'(pl4_r);
      accr_r <= accr_r + ACC_BITS'(pr4_r);
    end
    gl_r <= SH_BITS'(accl_r >>> (COEF_BITS - 2)) * gain_s;
    gr_r <= SH_BITS'(accr_r >>> (COEF_BITS - 2)) * gain_s;
    if (f1_v_r) begin
      res_l_r <= mute ? '0 : sat(gl_r);
      res_r_r <= (mute || mono) ? '0 : sat(gr_r);
    end
  end

  assign busy    = s1_r.vld | s2_v_r | s3_v_r | s4_v_r;
  assign res_vld = res_vld_r;
  assign res_l   = res_l_r;
  assign res_r   = res_r_r;

endmodule

// File: hdl/windowed_sinc_resampler_core.sv
// channel  | dir | handshake               | beat contents
// in_      | in  | in_tvalid / in_tready   | tuser action, tdata index/value/delta/left/right
// out_     | out | out_tvalid / out_tready | tdata left/right, tlast last frame of the run
// cfg_     | in  | cfg_valid / cfg_ready   | cfg_index register, cfg_data value
//
// a load beat leaves the core ready for the next beat; a sample beat issues, per output
// frame, lb + rb taps (taps of both wings through one shared mac, one read of each
// memory per tap), for up to 8 frames. the next input beat is taken once the last
// frame sits in the output register. reset is synchronous, clears control state and
// the history valid bits at once. out_tready low only holds the emit step.
module windowed_sinc_resampler_core import wsr_pkg::*; #(
  parameter int TABLE_DEPTH    = 4096,
  parameter int HISTORY_DEPTH  = 32,
  parameter int MAX_ZERO_CROSS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // [11:0] coef_index, [35:12] coef_value, [59:36] coef_delta,
  // [83:60] sample_left, [107:84] sample_right, [111:108] zero
  input  logic [111:0]             in_tdata,
  input  logic                     in_tuser,  // [0] action
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // [23:0] out_left, [47:24] out_right
  output logic [47:0]              out_tdata,
  output logic                     out_tlast,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int TAW = $clog2(TABLE_DEPTH);
  localparam int HPW = $clog2(HISTORY_DEPTH);
  localparam int ZW  = 5;
  localparam int TW  = 6;
  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(2**PHASE_BITS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_TAPS, ST_DRAIN, ST_FIN, ST_EMIT
  } state_t;

  state_t                  state_r;
  logic [STEP_BITS-1:0]    step_r;
  logic [3:0]              zc_r, plog_r;
  logic [1:0]              chan_r;
  logic [GAIN_BITS-1:0]    gain_r;
  logic                    mute_r;
  logic [PHASE_W-1:0]      phase_r;
  logic [HPW-1:0]          wp_r;
  logic [2:0]              cnt_r;
  logic [PHASE_BITS-1:0]   f0_r, f1_r;
  logic [W_BITS-1:0]       g_r;
  logic [TW-1:0]           lb_r, tot_r, t_r;
  logic                    out_tvalid_r, out_last_r;
  sample_t                 out_l_r, out_r_r;

  logic                    in_acc, coef_we, hist_we, mono;
  logic [ZW-1:0]           zc;
  logic [STEP_BITS-1:0]    step_eff;
  logic [PHASE_BITS-1:0]   frac;
  logic [W_BITS-1:0]       g;
  logic [31:0]             f0_w, f1_w;
  logic [TW-1:0]           lb_nxt, rb_nxt, k;
  logic                    left;
  logic [IDX_W-1:0]        idx;
  logic [HPW-1:0]          slot;
  logic [PHASE_W-1:0]      ph_nxt;
  logic                    last;
  tap_t                    tap;
  coef_t                   tab_d, del_d;
  sample_t                 hl_d, hr_d, res_l, res_r;
  logic                    mac_busy, res_vld;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid & in_tready;
  assign coef_we   = in_acc & in_tuser & (32'(in_tdata[11:0]) < TABLE_DEPTH);
  assign hist_we   = in_acc & ~in_tuser;
  assign mono      = (chan_r == 2'd1);

  always_comb begin
    if (zc_r == 4'd0) begin
      zc = ZW'(1);
    end else if (ZW'(zc_r) > ZW'(MAX_ZERO_CROSS)) begin
      zc = ZW'(MAX_ZERO_CROSS);
    end else begin
      zc = ZW'(zc_r);
    end
  end

  assign step_eff = (step_r < STEP_BITS'(MIN_STEP)) ? STEP_BITS'(MIN_STEP) : step_r;
  assign frac     = phase_r[PHASE_BITS-1:0];
  assign g        = W_BITS'(2**PHASE_BITS) - W_BITS'(frac);
  assign f0_w     = 32'(frac) << plog_r;
  assign f1_w     = 32'(g) << plog_r;

  // wing lengths: one table entry per crossing, one less when the fraction passes 1
  always_comb begin
    if (plog_r == 4'd0) begin
      lb_nxt = TW'(zc) + TW'(1) - TW'(f0_w[31:16]);
      rb_nxt = TW'(zc) + TW'(1) - TW'(f1_w[31:16]);
    end else begin
      lb_nxt = (f0_w[31:16] <= 16'd1) ? TW'(zc) : TW'(zc) - TW'(1);
      rb_nxt = (f1_w[31:16] <= 16'd1) ? TW'(zc) : TW'(zc) - TW'(1);
    end
  end

  // left wing walks back from the centre, right wing forward from it
  always_comb begin
    left = (t_r < lb_r);
    k    = left ? t_r : t_r - lb_r;
    idx  = IDX_W'(left ? f0_r : f1_r) + (IDX_W'(k) << plog_r);
    if (left) begin
      slot = wp_r - HPW'(1) - HPW'(zc) - HPW'(k);
    end else begin
      slot = wp_r - HPW'(zc) + HPW'(k);
    end
    tap.vld = (state_r == ST_TAPS) && (t_r < tot_r);
    tap.w   = left ? W_BITS'(frac) : g_r;
    tap.inr = (idx < IDX_W'(TABLE_DEPTH));
  end

  assign ph_nxt = phase_r + PHASE_W'(step_eff);
  assign last   = (ph_nxt >= PHASE_ONE) || (cnt_r == 3'(MAX_OUT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= STEP_BITS'(65536);
      zc_r         <= 4'd5;
      plog_r       <= 4'd9;
      chan_r       <= 2'd2;
      gain_r       <= GAIN_BITS'(16384);
      mute_r       <= 1'b0;
      phase_r      <= '0;
      wp_r         <= '0;
      cnt_r        <= '0;
      t_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_STEP: step_r <= cfg_data;
          REG_ZC:   zc_r   <= cfg_data[3:0];
          REG_PLOG: plog_r <= cfg_data[3:0];
          REG_CHAN: chan_r <= cfg_data[1:0];
          REG_GAIN: gain_r <= cfg_data[GAIN_BITS-1:0];
          REG_MUTE: mute_r <= cfg_data[0];
          default:  ;
        endcase
      end
      // the emit step refills the output register itself
      if (out_tvalid_r && out_tready && (state_r != ST_EMIT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (hist_we) begin
            wp_r  <= wp_r + HPW'(1);
            cnt_r <= '0;
            if (phase_r < PHASE_ONE) begin
              state_r <= ST_SETUP;
            end else begin
              phase_r <= phase_r - PHASE_ONE;
            end
          end
        end
        ST_SETUP: begin
          f0_r    <= f0_w[31:16];
          f1_r    <= f1_w[31:16];
          g_r     <= g;
          lb_r    <= lb_nxt;
          tot_r   <= lb_nxt + rb_nxt;
          t_r     <= '0;
          state_r <= ST_TAPS;
        end
        ST_TAPS: begin
          if (t_r < tot_r) begin
            t_r <= t_r + TW'(1);
          end else begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!mac_busy) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (res_vld) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_l_r      <= res_l;
            out_r_r      <= res_r;
            out_last_r   <= last;
            cnt_r        <= cnt_r + 3'd1;
            if (last) begin
              phase_r <= (ph_nxt >= PHASE_ONE) ? ph_nxt - PHASE_ONE : '0;
              state_r <= ST_IDLE;
            end else begin
              phase_r <= ph_nxt;
              state_r <= ST_SETUP;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  wsr_coef_mem #(.DEPTH(TABLE_DEPTH)) u_coef (
    .clk   (clk),
    .we    (coef_we),
    .waddr (TAW'(in_tdata[11:0])),
    .wval  (coef_t'(in_tdata[35:12])),
    .wdel  (coef_t'(in_tdata[59:36])),
    .raddr (idx[TAW-1:0]),
    .rval  (tab_d),
    .rdel  (del_d)
  );

  wsr_hist_mem #(.DEPTH(HISTORY_DEPTH)) u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (hist_we),
    .waddr (wp_r),
    .wl    (sample_t'(in_tdata[83:60])),
    .wr    (sample_t'(in_tdata[107:84])),
    .raddr (slot),
    .rl    (hl_d),
    .rr    (hr_d)
  );

  wsr_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .tap_i   (tap),
    .tab_i   (tab_d),
    .del_i   (del_d),
    .hl_i    (hl_d),
    .hr_i    (hr_d),
    .acc_clr (state_r == ST_SETUP),
    .fin_go  ((state_r == ST_DRAIN) && !mac_busy),
    .gain    (gain_r),
    .mute    (mute_r),
    .mono    (mono),
    .busy    (mac_busy),
    .res_vld (res_vld),
    .res_l   (res_l),
    .res_r   (res_r)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_r_r, out_l_r};
  assign out_tlast  = out_last_r;

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !mac_busy) else $error("input taken while taps in flight");

  a_mute_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && mute_r) |-> (out_tdata == '0)) else $error("muted frame not zero");

  a_mono_right: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && mono) |-> (out_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] == '0))
    else $error("mono right channel not zero");

  a_tap_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TAPS) |-> (t_r <= tot_r)) else $error("tap counter overran");

endmodule

// File: dv/wsr_scoreboard.sv
`timescale 1ns / 100ps

module wsr_scoreboard import wsr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [111:0]             in_tdata,
  input  logic                     in_tuser,
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [47:0]              out_tdata,
  input  logic                     out_tlast,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       errors,
  output int                       pending
);

  localparam int TBL_N  = 4096;
  localparam int HIST_N = 32;

  typedef struct {
    logic [23:0] left;
    logic [23:0] right;
    logic        last;
  } frame_t;

  frame_t frame_q[$];

  sample_t hist_l[HIST_N];
  sample_t hist_r[HIST_N];
  coef_t   coefs[TBL_N];
  coef_t   deltas[TBL_N];
  longint  phase;
  int      wr_ptr;

  logic [19:0] step_reg;
  logic [3:0]  zc_reg;
  logic [3:0]  plog_reg;
  logic [1:0]  chan_reg;
  logic [15:0] gain_reg;
  logic        mute_reg;

  task automatic report(input string what, input logic [23:0] got, input logic [23:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic longint tap_coef(longint idx, longint w);
    if (idx >= TBL_N) return 0;
    return longint'(coefs[idx]) + ((w * longint'(deltas[idx])) >>> 16);
  endfunction

  function automatic longint hist_tap(bit right, longint age);
    int slot;
    slot = int'((wr_ptr + HIST_N * 64 - 1 - age) % HIST_N);
    return right ? longint'(hist_r[slot]) : longint'(hist_l[slot]);
  endfunction

  // one channel of one output frame at the current phase
  function automatic logic [23:0] resample_chan(bit right, longint zc, longint lg);
    longint pc, frac, g, f0, f1, fs, lb, rb, acc, v, j;
    pc   = longint'(1) << lg;
    frac = phase & 16'hffff;
    g    = 65536 - frac;
    f0   = (frac << lg) >> 16;
    f1   = (g << lg) >> 16;
    fs   = pc * zc + 1;
    lb   = (fs - f0) / pc;
    rb   = (fs - f1) / pc;
    acc  = 0;
    for (longint m = 0; m < lb; m++) begin
      j = zc - lb + 1 + m;
      acc += hist_tap(right, 2 * zc - j) * tap_coef(f0 + (lb - 1 - m) * pc, frac);
    end
    for (longint m = 0; m < rb; m++) begin
      j = zc + 1 + m;
      acc += hist_tap(right, 2 * zc - j) * tap_coef(f1 + m * pc, g);
    end
    v = acc >>> 22;
    v = (v * longint'(gain_reg)) >>> 14;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    if (mute_reg) v = 0;
    return v[23:0];
  endfunction

  task automatic push_sample(logic [111:0] d);
    longint zc, step;
    int n;
    frame_t f;
    hist_l[wr_ptr] = d[83:60];
    hist_r[wr_ptr] = d[107:84];
    wr_ptr = (wr_ptr + 1) % HIST_N;
    zc = zc_reg;
    if (zc < 1) zc = 1;
    if (zc > 8) zc = 8;
    step = (step_reg < MIN_STEP) ? MIN_STEP : step_reg;
    n = 0;
    while (phase < 65536 && n < MAX_OUT) begin
      f.left  = resample_chan(1'b0, zc, plog_reg);
      f.right = (chan_reg == 2'd1) ? 24'd0 : resample_chan(1'b1, zc, plog_reg);
      f.last  = 1'b0;
      frame_q.push_back(f);
      n++;
      phase += step;
    end
    if (n > 0) frame_q[$].last = 1'b1;
    phase = (phase >= 65536) ? phase - 65536 : 0;
    phase &= 24'hffffff;
  endtask

  always @(posedge clk) begin
    frame_t exp_f;
    if (!rst_n) begin
      frame_q.delete();
      foreach (hist_l[i]) begin
        hist_l[i] = '0;
        hist_r[i] = '0;
      end
      phase    = 0;
      wr_ptr   = 0;
      step_reg = 20'd65536;
      zc_reg   = 4'd5;
      plog_reg = 4'd9;
      chan_reg = 2'd2;
      gain_reg = 16'd16384;
      mute_reg = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (frame_q.size() == 0) begin
          report("beat with none predicted", out_tdata[23:0], 24'h0);
        end else begin
          exp_f = frame_q.pop_front();
          if (out_tdata[23:0] !== exp_f.left) report("left", out_tdata[23:0], exp_f.left);
          if (out_tdata[47:24] !== exp_f.right) report("right", out_tdata[47:24], exp_f.right);
          if (out_tlast !== exp_f.last) report("tlast", 24'(out_tlast), 24'(exp_f.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_STEP: step_reg = cfg_data[19:0];
          REG_ZC:   zc_reg   = cfg_data[3:0];
          REG_PLOG: plog_reg = cfg_data[3:0];
          REG_CHAN: chan_reg = cfg_data[1:0];
          REG_GAIN: gain_reg = cfg_data[15:0];
          REG_MUTE: mute_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser) begin
          coefs[in_tdata[11:0]]  = in_tdata[35:12];
          deltas[in_tdata[11:0]] = in_tdata[59:36];
        end else begin
          push_sample(in_tdata);
        end
      end
    end
    pending = frame_q.size();
  end

  initial begin
    errors  = 0;
    pending = 0;
  end

endmodule

// File: dv/tb_windowed_sinc_resampler_core.sv
`timescale 1ns / 100ps

module tb_windowed_sinc_resampler_core;
  import wsr_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [111:0]             in_tdata = '0;
  logic                     in_tuser = 1'b0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [47:0]              out_tdata;
  logic                     out_tlast;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  int                       errors;
  int                       pending;

  bit no_idle;
  bit hold_req;

  always #1 clk = ~clk;

  windowed_sinc_resampler_core dut (.*);

  wsr_scoreboard u_sb (.*);

  function automatic int idle_len();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // result side: random stalls plus one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        for (n = 0; n < 400; n++) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready = (idle_len() == 0);
    end
  end

  task automatic send_beat(input bit act, input logic [11:0] idx, input logic [23:0] val,
                           input logic [23:0] dlt, input logic [23:0] l, input logic [23:0] r);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = act;
    in_tdata  = {4'b0, r, l, dlt, val, idx};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic load_coef(input logic [11:0] idx);
    if ($urandom_range(0, 1))
      send_beat(1'b1, idx, 24'($urandom_range(0, 1 << 19) - (1 << 18)),
                24'($urandom_range(0, 1 << 15) - (1 << 14)), 24'($urandom), 24'($urandom));
    else
      send_beat(1'b1, idx, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
  endtask

  task automatic send_sample(input logic [23:0] l, input logic [23:0] r);
    send_beat(1'b0, 12'($urandom), 24'($urandom), 24'($urandom), l, r);
  endtask

  // loads cause no result, so leave time for a sample still in flight
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [19:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_mode(input logic [19:0] step, input logic [3:0] zc, input logic [3:0] plog,
                          input logic [1:0] chan, input logic [15:0] gain, input bit mute);
    wait_drained();
    write_reg(REG_STEP, step);
    write_reg(REG_ZC, 20'(zc));
    write_reg(REG_PLOG, 20'(plog));
    write_reg(REG_CHAN, 20'(chan));
    write_reg(REG_GAIN, 20'(gain));
    write_reg(REG_MUTE, 20'(mute));
  endtask

  task automatic random_run(input int count);
    logic [23:0] l, r;
    for (int i = 0; i < count; i++) begin
      no_idle = ($urandom_range(0, 29) == 0) ? ~no_idle : no_idle;
      if ($urandom_range(0, 4) == 0) begin
        load_coef(12'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0: begin l = 24'h7fffff; r = 24'h800000; end
          1: begin l = 24'($urandom_range(0, 1 << 20) - (1 << 19)); r = -l; end
          default: begin l = 24'($urandom); r = 24'($urandom); end
        endcase
        send_sample(l, r);
      end
    end
  endtask

  initial begin
    no_idle  = 1'b0;
    hold_req = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // taps reach table entries up to phases times crossings, kept at 128 or less below
    for (int i = 0; i <= 128; i++) load_coef(i[11:0]);

    // directed: field extremes at unity step
    send_beat(1'b1, 12'd0, 24'h7fffff, 24'h800000, 24'h0, 24'h0);
    send_beat(1'b1, 12'hfff, 24'h800000, 24'h7fffff, 24'h0, 24'h0);
    set_mode(20'd65536, 4'd5, 4'd4, 2'd2, 16'd16384, 1'b0);
    send_sample(24'h7fffff, 24'h7fffff);
    send_sample(24'h800000, 24'h800000);
    send_sample(24'h000000, 24'hffffff);
    send_sample(24'h555555, 24'haaaaaa);
    send_sample(24'haaaaaa, 24'h555555);
    for (int i = 0; i < 6; i++) send_sample(24'($urandom), 24'($urandom));

    // densest output, mono, full gain
    set_mode(20'd8192, 4'd8, 4'd4, 2'd1, 16'hffff, 1'b0);
    for (int i = 0; i < 4; i++) send_sample(24'h7fffff, 24'h123456);
    hold_req = 1'b1;
    random_run(40);

    // decimation, single crossing, zero gain
    set_mode(20'hfffff, 4'd1, 4'd7, 2'd2, 16'd0, 1'b0);
    random_run(30);
    set_mode(20'd524288, 4'd1, 4'd7, 2'd2, 16'd16384, 1'b0);
    random_run(30);

    // step below minimum, zero crossings below range, mute
    set_mode(20'd100, 4'd0, 4'd6, 2'd3, 16'd30000, 1'b1);
    random_run(30);

    // zero crossings above range, channel count zero
    set_mode(20'($urandom_range(20000, 100000)), 4'd15, 4'd4, 2'd0, 16'd16384, 1'b0);
    random_run(40);
    set_mode(20'($urandom_range(8192, 200000)), 4'($urandom_range(1, 8)),
             4'($urandom_range(0, 4)), 2'($urandom_range(1, 2)), 16'($urandom), 1'b0);
    random_run(40);

    wait_drained();
    if (errors == 0)
      $display("tb_windowed_sinc_resampler_core: done, clean");
    else
      $display("tb_windowed_sinc_resampler_core: done, errors");
    $finish;
  end

  initial begin
    #1900000;
    $display("tb_windowed_sinc_resampler_core: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
hdl/wsr_pkg.sv
hdl/wsr_coef_mem.sv
hdl/wsr_hist_mem.sv
hdl/wsr_mac.sv
hdl/windowed_sinc_resampler_core.sv
dv/wsr_scoreboard.sv
dv/tb_windowed_sinc_resampler_core.sv
